// File: rtl/rfd_pkg.sv
// Shared constants, codes and payload types of the rectangle fill display sequencer.
`default_nettype none

package rfd_pkg;

	localparam int MAX_PANEL_DIM = 1024;
	localparam int DIM_W         = $clog2(MAX_PANEL_DIM + 1);
	localparam int PIX_W         = $clog2(MAX_PANEL_DIM * MAX_PANEL_DIM + 1);
	localparam int CFG_W         = 11;
	localparam int OFS_W         = 10;
	localparam int CFG_IDX_W     = 2;
	localparam int QUEUE_DEPTH   = 4;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET    = 2'd3;

	localparam logic [CFG_W-1:0] PANEL_WIDTH_RST  = 11'd240;
	localparam logic [CFG_W-1:0] PANEL_HEIGHT_RST = 11'd320;
	localparam logic [OFS_W-1:0] OFFSET_RST       = 10'd0;

	// request kinds
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_SLOT  = 1'b1;

	// display command bytes
	localparam logic [7:0] DC_COLUMN_SET   = 8'h2A;
	localparam logic [7:0] DC_ROW_SET      = 8'h2B;
	localparam logic [7:0] DC_MEMORY_WRITE = 8'h2C;

	// header byte positions
	localparam logic [3:0] HS_COL_CMD   = 4'd0;
	localparam logic [3:0] HS_COL_S_HI  = 4'd1;
	localparam logic [3:0] HS_COL_S_LO  = 4'd2;
	localparam logic [3:0] HS_COL_E_HI  = 4'd3;
	localparam logic [3:0] HS_COL_E_LO  = 4'd4;
	localparam logic [3:0] HS_ROW_CMD   = 4'd5;
	localparam logic [3:0] HS_ROW_S_HI  = 4'd6;
	localparam logic [3:0] HS_ROW_S_LO  = 4'd7;
	localparam logic [3:0] HS_ROW_E_HI  = 4'd8;
	localparam logic [3:0] HS_ROW_E_LO  = 4'd9;
	localparam logic [3:0] HS_MEM_CMD   = 4'd10;

	typedef struct packed {
		logic        cmd;
		logic [15:0] left;
		logic [15:0] top;
		logic [15:0] rect_width;
		logic [15:0] rect_height;
		logic [15:0] fill_color;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       last;
	} tx_item_t;

	typedef struct packed {
		logic [CFG_W-1:0] panel_width;
		logic [CFG_W-1:0] panel_height;
		logic [OFS_W-1:0] column_offset;
		logic [OFS_W-1:0] row_offset;
	} rfd_cfg_t;

	// one classified request between front and back
	typedef struct packed {
		logic             is_start;
		logic [15:0]      col_start;
		logic [15:0]      col_end;
		logic [15:0]      row_start;
		logic [15:0]      row_end;
		logic [15:0]      color;
		logic [PIX_W-1:0] pixels;
	} fill_req_t;

endpackage

`default_nettype wire

// File: rtl/rect_fill_display_sequencer.sv
// Top level of the rectangle fill display sequencer: config registers, front, queue, back.
// Path: a transmit-slot request passes the front clip stage, the queue and the output register
// before its byte shows on tx_valid.
// Throughput: one request per cycle while the queue has room; every transmit slot yields one byte while a fill runs.
// The front stalls only when the queue is full; the back stalls only on tx_stall.
// Reset: panel 240 x 320, offsets zero, sequencer idle, queue and output register empty.
`default_nettype none

module rect_fill_display_sequencer
	import rfd_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wen,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 cmd_valid,
	output logic                      cmd_stall,
	input  wire cmd_item_t            cmd_item,
	output logic                      tx_valid,
	input  wire logic                 tx_stall,
	output tx_item_t                  tx_item
);

	rfd_cfg_t  cfg_q;
	logic      push;
	fill_req_t push_data;
	logic      full;
	logic      pop;
	fill_req_t pop_data;
	logic      empty;

	// Configuration registers; the user must write them only while the block is idle, which the
	// block does not enforce, so the front may read them directly when it clips a start request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.panel_width   <= PANEL_WIDTH_RST;
			cfg_q.panel_height  <= PANEL_HEIGHT_RST;
			cfg_q.column_offset <= OFFSET_RST;
			cfg_q.row_offset    <= OFFSET_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_PANEL_WIDTH:   cfg_q.panel_width   <= cfg_data;
				CFG_PANEL_HEIGHT:  cfg_q.panel_height  <= cfg_data;
				CFG_COLUMN_OFFSET: cfg_q.column_offset <= cfg_data[OFS_W-1:0];
				CFG_ROW_OFFSET:    cfg_q.row_offset    <= cfg_data[OFS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: clip the rectangle, compute window ends, drop out-of-panel starts,
	// and multiply the clipped size into a pixel count on the way into the queue.
	rfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// Queue: decouple the request side from the byte side.
	rfd_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// Back: latch a start when idle, ignore it when busy; on each slot while a fill runs, emit the
	// next header or pixel byte into the output register.
	rfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop_data (pop_data),
		.pop      (pop),
		.tx_valid (tx_valid),
		.tx_stall (tx_stall),
		.tx_item  (tx_item)
	);

endmodule

`default_nettype wire

// File: rtl/rfd_front.sv
// Front end: accepts requests, clips the rectangle, drops rejected starts, feeds the queue.
`default_nettype none

module rfd_front
	import rfd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire rfd_cfg_t  cfg,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_item_t cmd_item,
	output logic           push,
	output fill_req_t      push_data,
	input  wire logic      full
);

	logic             v_s1;
	logic             is_start_s1;
	logic [15:0]      col_start_s1;
	logic [15:0]      col_end_s1;
	logic [15:0]      row_start_s1;
	logic [15:0]      row_end_s1;
	logic [15:0]      color_s1;
	logic [DIM_W-1:0] w_s1;
	logic [DIM_W-1:0] h_s1;

	logic        accept;
	logic [15:0] pw;
	logic [15:0] ph;
	logic [15:0] col_ofs;
	logic [15:0] row_ofs;
	logic        col_over;
	logic        row_over;
	logic        reject;
	logic [15:0] w_clip;
	logic [15:0] h_clip;
	logic [15:0] col_end;
	logic [15:0] row_end;
	logic [2*DIM_W-1:0] prod;

	// panel sizes above the maximum act as the maximum
	assign pw = (16'(cfg.panel_width) > 16'(MAX_PANEL_DIM)) ? 16'(MAX_PANEL_DIM)
		: 16'(cfg.panel_width);
	assign ph = (16'(cfg.panel_height) > 16'(MAX_PANEL_DIM)) ? 16'(MAX_PANEL_DIM)
		: 16'(cfg.panel_height);
	assign col_ofs = 16'(cfg.column_offset);
	assign row_ofs = 16'(cfg.row_offset);

	assign reject   = (cmd_item.left >= pw) || (cmd_item.top >= ph);
	assign col_over = (17'(cmd_item.left) + 17'(cmd_item.rect_width)) > 17'(pw);
	assign row_over = (17'(cmd_item.top) + 17'(cmd_item.rect_height)) > 17'(ph);
	assign w_clip   = col_over ? pw - cmd_item.left : cmd_item.rect_width;
	assign h_clip   = row_over ? ph - cmd_item.top : cmd_item.rect_height;
	// a clipped end sits at the panel edge whatever the start
	assign col_end  = col_over ? pw + col_ofs - 16'd1
		: cmd_item.left + cmd_item.rect_width + col_ofs - 16'd1;
	assign row_end  = row_over ? ph + row_ofs - 16'd1
		: cmd_item.top + cmd_item.rect_height + row_ofs - 16'd1;

	assign push      = v_s1 && !full;
	assign cmd_stall = v_s1 && full;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= (cmd_item.cmd == CMD_SLOT) || !reject;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_start_s1  <= (cmd_item.cmd == CMD_START);
			col_start_s1 <= cmd_item.left + col_ofs;
			col_end_s1   <= col_end;
			row_start_s1 <= cmd_item.top + row_ofs;
			row_end_s1   <= row_end;
			color_s1     <= cmd_item.fill_color;
			w_s1         <= w_clip[DIM_W-1:0];
			h_s1         <= h_clip[DIM_W-1:0];
		end
	end

	assign prod = w_s1 * h_s1;

	always_comb begin
		push_data.is_start  = is_start_s1;
		push_data.col_start = col_start_s1;
		push_data.col_end   = col_end_s1;
		push_data.row_start = row_start_s1;
		push_data.row_end   = row_end_s1;
		push_data.color     = color_s1;
		push_data.pixels    = prod[PIX_W-1:0];
	end

endmodule

`default_nettype wire

// File: rtl/rfd_queue.sv
// Short request queue between the front end and the byte sequencer.
`default_nettype none

module rfd_queue
	import rfd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire fill_req_t push_data,
	output logic           full,
	input  wire logic      pop,
	output fill_req_t      pop_data,
	output logic           empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	fill_req_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/rfd_back.sv
// Back end: steps through header and pixel bytes and holds the output register.
`default_nettype none

module rfd_back
	import rfd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      empty,
	input  wire fill_req_t pop_data,
	output logic           pop,
	output logic           tx_valid,
	input  wire logic      tx_stall,
	output tx_item_t       tx_item
);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_HEADER = 3'b010,
		PH_PIXEL  = 3'b100
	} phase_t;

	phase_t           phase_q;
	phase_t           phase_d;
	logic [3:0]       step_q;
	logic [PIX_W-1:0] pix_q;
	logic [PIX_W-1:0] pix_d;
	logic [PIX_W-1:0] pix_dec;
	logic             low_q;
	logic [15:0]      col_start_q;
	logic [15:0]      col_end_q;
	logic [15:0]      row_start_q;
	logic [15:0]      row_end_q;
	logic [15:0]      color_q;

	logic     out_v_q;
	tx_item_t out_q;

	logic     out_free;
	logic     load;
	logic     emit;
	tx_item_t res;

	assign out_free = !out_v_q || !tx_stall;
	assign pop      = !empty && out_free;
	assign load     = pop && pop_data.is_start && (phase_q == PH_IDLE);
	assign emit     = pop && !pop_data.is_start && (phase_q != PH_IDLE);
	assign pix_dec  = (pix_q != '0) ? pix_q - PIX_W'(1) : pix_q;

	always_comb begin
		res     = '0;
		phase_d = phase_q;
		pix_d   = pix_q;
		case (phase_q)
			PH_HEADER: begin
				res.is_data = 1'b1;
				case (step_q)
					HS_COL_CMD: begin
						res.out_byte = DC_COLUMN_SET;
						res.is_data  = 1'b0;
					end
					HS_COL_S_HI: res.out_byte = col_start_q[15:8];
					HS_COL_S_LO: res.out_byte = col_start_q[7:0];
					HS_COL_E_HI: res.out_byte = col_end_q[15:8];
					HS_COL_E_LO: res.out_byte = col_end_q[7:0];
					HS_ROW_CMD: begin
						res.out_byte = DC_ROW_SET;
						res.is_data  = 1'b0;
					end
					HS_ROW_S_HI: res.out_byte = row_start_q[15:8];
					HS_ROW_S_LO: res.out_byte = row_start_q[7:0];
					HS_ROW_E_HI: res.out_byte = row_end_q[15:8];
					HS_ROW_E_LO: res.out_byte = row_end_q[7:0];
					default: begin
						res.out_byte = DC_MEMORY_WRITE;
						res.is_data  = 1'b0;
					end
				endcase
				if (step_q >= HS_MEM_CMD) begin
					if (pix_q == '0) begin
						res.last = 1'b1;
						phase_d  = PH_IDLE;
					end else begin
						phase_d = PH_PIXEL;
					end
				end
			end
			PH_PIXEL: begin
				res.is_data = 1'b1;
				if (!low_q) begin
					res.out_byte = color_q[15:8];
				end else begin
					res.out_byte = color_q[7:0];
					pix_d        = pix_dec;
					if (pix_dec == '0) begin
						res.last = 1'b1;
						phase_d  = PH_IDLE;
					end
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q  <= '0;
			pix_q   <= '0;
			low_q   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q <= PH_HEADER;
				step_q  <= HS_COL_CMD;
				pix_q   <= pop_data.pixels;
				low_q   <= 1'b0;
			end else if (emit) begin
				phase_q <= phase_d;
				pix_q   <= pix_d;
				if (phase_q == PH_HEADER) begin
					step_q <= step_q + 4'd1;
				end else begin
					low_q <= !low_q;
				end
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (!tx_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			col_start_q <= pop_data.col_start;
			col_end_q   <= pop_data.col_end;
			row_start_q <= pop_data.row_start;
			row_end_q   <= pop_data.row_end;
			color_q     <= pop_data.color;
		end
		if (emit) begin
			out_q <= res;
		end
	end

	assign tx_valid = out_v_q;
	assign tx_item  = out_q;

endmodule

`default_nettype wire
